// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file of the RTL folder.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define ZVD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds during reset.
`define ZVD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/zvd_pkg.sv -----
// Types and constants of the zero-velocity detector.
// No dependencies; imported by the detector top level and its checker.
`timescale 1ns / 1ps

package zvd_pkg;

  // Sample and sensor layout
  localparam int unsigned AXIS_W          = 16;
  localparam int unsigned NUM_AXES        = 6;
  localparam int unsigned AXES_PER_SENSOR = 3;
  localparam int unsigned NUM_SENSORS     = 2;
  // Sensor index of an axis is axis / AXES_PER_SENSOR (gyro axes sit on top)
  localparam int unsigned GYRO            = 1;
  localparam int unsigned ACCEL           = 0;

  // Arithmetic widths that do not depend on the window length
  localparam int unsigned AXD_W  = AXIS_W + 1;  // difference of two samples
  localparam int unsigned AXSQ_W = 32;          // square, or sum of three squares
  localparam int unsigned DSQ_W  = AXSQ_W + 2;  // signed difference of square sums

  // Register field widths
  localparam int unsigned DISP_W  = 16;
  localparam int unsigned LIMIT_W = 39;
  localparam int unsigned GRAV_W  = 15;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 39;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_DISPARITY = 3'd0,
    CFG_GYRO_LIMIT    = 3'd1,
    CFG_ACCEL_LIMIT   = 3'd2,
    CFG_GRAVITY_LEVEL = 3'd3,
    CFG_GRAVITY_TOL   = 3'd4
  } zvd_cfg_e;

  // One IMU sample as stored in the ring: index 5 is gyro_x, index 0 is accel_z
  typedef logic [NUM_AXES-1:0][AXIS_W-1:0] zvd_axes_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] gyro_x;
    logic signed [AXIS_W-1:0] gyro_y;
    logic signed [AXIS_W-1:0] gyro_z;
    logic signed [AXIS_W-1:0] accel_x;
    logic signed [AXIS_W-1:0] accel_y;
    logic signed [AXIS_W-1:0] accel_z;
    logic [DISP_W-1:0]        disparity;
  } zvd_in_t;

  typedef struct packed {
    logic stationary;
    logic window_full;
    logic gyro_quiet;
    logic accel_quiet;
    logic gravity_match;
  } zvd_out_t;

endpackage

// ----- rtl/core/zvd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; read returns the old word when read and write share an address.
`timescale 1ns / 1ps

module zvd_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/zero_velocity_detector.sv -----
// Zero-velocity detector: sliding-window IMU variance test; uses zvd_pkg and zvd_ram.
// Pipeline: input register with ring read, then squares, running sums, squared sums,
// compares. Throughput: one item per cycle when the output does not stall, set by one
// ring write plus one ring read per cycle; output stalls back up through the stages.
// Reset (async, active low) clears counters, sums, stage valids and config registers to reset
// values; the sample ring is not cleared and its read data is used only once the window is full.
`timescale 1ns / 1ps

module zero_velocity_detector #(
  parameter int unsigned WINDOW = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  zvd_pkg::zvd_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output zvd_pkg::zvd_out_t              out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [zvd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [zvd_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import zvd_pkg::*;

  // Widths that follow from the window length
  localparam int unsigned AW     = $clog2(WINDOW);
  localparam int unsigned CW     = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W  = AXIS_W + AW;
  localparam int unsigned SQ_W   = DSQ_W + AW;
  localparam int unsigned PR_W   = 2 * SUM_W;
  localparam int unsigned MS_W   = PR_W + 1;
  localparam int unsigned WSQ_W  = SQ_W + CW;
  localparam int unsigned WLIM_W = LIMIT_W + CW;
  localparam int unsigned GL_W   = GRAV_W + 1 + CW;
  localparam int unsigned GSQ_W  = 2 * GL_W;
  localparam int unsigned CMP_W  = (WSQ_W > WLIM_W) ? WSQ_W : WLIM_W;
  localparam int unsigned GCMP_W = (MS_W > GSQ_W) ? MS_W : GSQ_W;

  // Configuration registers
  logic [DISP_W-1:0]                      max_disp_q;
  logic [NUM_SENSORS-1:0][LIMIT_W-1:0]    limit_q;
  logic [GRAV_W-1:0]                      grav_level_q;
  logic [GRAV_W-1:0]                      grav_tol_q;
  logic                                   cfg_write;

  // Thresholds scaled by the window length
  logic [NUM_SENSORS-1:0][WLIM_W-1:0]     wlim_q;
  logic [GL_W-1:0]                        hi_lin_q;
  logic [GL_W-1:0]                        lo_lin_q;
  logic                                   lo_en_q;
  logic [GSQ_W-1:0]                       hi_sq_q;
  logic [GSQ_W-1:0]                       lo_sq_q;

  // Ring control
  logic [AW-1:0]                          wp_q;
  logic [AW-1:0]                          wp_next;
  logic [CW-1:0]                          fill_q;
  logic                                   full_before;
  logic                                   full_after;
  logic                                   accept;
  zvd_axes_t                              in_axes;
  zvd_axes_t                              ram_rdata;

  // Stage handshake
  logic                                   rdy1, rdy2, rdy3, rdy4, rdy5;

  // Stage 1: new sample, old sample arrives from the ring
  logic                                   s1_v_q;
  zvd_axes_t                              s1_axes_q;
  logic                                   s1_old_v_q;
  logic                                   s1_full_q;
  logic [DISP_W-1:0]                      s1_disp_q;

  // Stage 2: per-axis and per-sensor deltas
  logic                                   s2_v_q;
  logic [NUM_AXES-1:0][AXD_W-1:0]         s2_dax_q, s2_dax_d;
  logic [NUM_SENSORS-1:0][DSQ_W-1:0]      s2_dsq_q, s2_dsq_d;
  logic [NUM_SENSORS-1:0][AXSQ_W-1:0]     new_sq, old_sq;
  logic signed [AXIS_W-1:0]               new_ax, old_ax;
  logic                                   s2_full_q;
  logic                                   s2_disp_ok_q;

  // Stage 3: running sums over the window
  logic                                   s3_v_q;
  logic [NUM_AXES-1:0][SUM_W-1:0]         axis_sum_q;
  logic [NUM_SENSORS-1:0][SQ_W-1:0]       sqsum_q;
  logic                                   s3_full_q;
  logic                                   s3_disp_ok_q;

  // Stage 4: squared sums and scaled square sums
  logic                                   s4_v_q;
  logic [NUM_SENSORS-1:0][MS_W-1:0]       s4_ms_q, s4_ms_d;
  logic [NUM_SENSORS-1:0][WSQ_W-1:0]      s4_wsq_q, s4_wsq_d;
  logic signed [PR_W-1:0]                 sum_prod;
  logic                                   s4_full_q;
  logic                                   s4_disp_ok_q;

  // Stage 5: result register
  logic                                   out_v_q;
  zvd_out_t                               out_q, out_d;
  logic [NUM_SENSORS-1:0][CMP_W-1:0]      spread;
  logic [NUM_SENSORS-1:0]                 quiet;
  logic                                   upper_ok, lower_ok, grav_ok;

  // Handshake: a stage takes a new item when empty or when its item moves on
  assign rdy5        = !out_v_q || !out_stall_i;
  assign rdy4        = !s4_v_q || rdy5;
  assign rdy3        = !s3_v_q || rdy4;
  assign rdy2        = !s2_v_q || rdy3;
  assign rdy1        = !s1_v_q || rdy2;
  assign in_stall_o  = !rdy1;
  assign accept      = in_valid_i && rdy1;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // Configuration port always takes a transfer
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  // Ring pointer and fill level
  assign full_before = (fill_q == CW'(WINDOW));
  assign full_after  = full_before || (fill_q == CW'(WINDOW - 1));
  assign wp_next     = (wp_q == AW'(WINDOW - 1)) ? '0 : wp_q + AW'(1);
  assign in_axes     = {in_data_i.gyro_x, in_data_i.gyro_y, in_data_i.gyro_z,
                        in_data_i.accel_x, in_data_i.accel_y, in_data_i.accel_z};

  // Write the new sample and read the one it displaces at the same address
  zvd_ram #(
    .WIDTH (NUM_AXES * AXIS_W),
    .DEPTH (WINDOW)
  ) u_zvd_ram (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (wp_q),
    .wdata_i (in_axes),
    .re_i    (accept),
    .raddr_i (wp_q),
    .rdata_o (ram_rdata)
  );

  // Control state: configuration, ring pointers, running sums, stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_disp_q   <= '1;
      limit_q      <= '0;
      grav_level_q <= '0;
      grav_tol_q   <= '0;
      wp_q         <= '0;
      fill_q       <= '0;
      axis_sum_q   <= '0;
      sqsum_q      <= '0;
      s1_v_q       <= 1'b0;
      s2_v_q       <= 1'b0;
      s3_v_q       <= 1'b0;
      s4_v_q       <= 1'b0;
      out_v_q      <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (zvd_cfg_e'(cfg_index_i))
          CFG_MAX_DISPARITY: max_disp_q       <= cfg_data_i[DISP_W-1:0];
          CFG_GYRO_LIMIT:    limit_q[GYRO]    <= cfg_data_i[LIMIT_W-1:0];
          CFG_ACCEL_LIMIT:   limit_q[ACCEL]   <= cfg_data_i[LIMIT_W-1:0];
          CFG_GRAVITY_LEVEL: grav_level_q     <= cfg_data_i[GRAV_W-1:0];
          CFG_GRAVITY_TOL:   grav_tol_q       <= cfg_data_i[GRAV_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        wp_q <= wp_next;
        if (!full_before) begin
          fill_q <= fill_q + CW'(1);
        end
      end
      // Advance the running sums once per item leaving stage 2
      if (rdy3 && s2_v_q) begin
        for (int i = 0; i < NUM_AXES; i++) begin
          axis_sum_q[i] <= axis_sum_q[i] + SUM_W'($signed(s2_dax_q[i]));
        end
        for (int s = 0; s < NUM_SENSORS; s++) begin
          sqsum_q[s] <= sqsum_q[s] + SQ_W'($signed(s2_dsq_q[s]));
        end
      end
      if (rdy1) s1_v_q  <= in_valid_i;
      if (rdy2) s2_v_q  <= s1_v_q;
      if (rdy3) s3_v_q  <= s2_v_q;
      if (rdy4) s4_v_q  <= s3_v_q;
      if (rdy5) out_v_q <= s4_v_q;
    end
  end

  // Scale the thresholds into registers; the gravity bounds pass a linear then a squared register
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NUM_SENSORS; s++) begin
      wlim_q[s] <= WLIM_W'(limit_q[s]) * WLIM_W'(WINDOW);
    end
    hi_lin_q <= GL_W'(WINDOW) * (GL_W'(grav_level_q) + GL_W'(grav_tol_q));
    lo_lin_q <= GL_W'(WINDOW) * (GL_W'(grav_level_q) - GL_W'(grav_tol_q));
    lo_en_q  <= (grav_level_q >= grav_tol_q);
    hi_sq_q  <= GSQ_W'(hi_lin_q) * GSQ_W'(hi_lin_q);
    lo_sq_q  <= GSQ_W'(lo_lin_q) * GSQ_W'(lo_lin_q);
  end

  // Stage 1 to 2: sample deltas and square-sum deltas; drop the old sample until full
  always_comb begin
    new_sq = '0;
    old_sq = '0;
    new_ax = '0;
    old_ax = '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      new_ax      = $signed(s1_axes_q[i]);
      old_ax      = s1_old_v_q ? $signed(ram_rdata[i]) : '0;
      s2_dax_d[i] = AXD_W'(new_ax) - AXD_W'(old_ax);
      new_sq[i / AXES_PER_SENSOR] += AXSQ_W'(AXSQ_W'(new_ax) * AXSQ_W'(new_ax));
      old_sq[i / AXES_PER_SENSOR] += AXSQ_W'(AXSQ_W'(old_ax) * AXSQ_W'(old_ax));
    end
    for (int s = 0; s < NUM_SENSORS; s++) begin
      s2_dsq_d[s] = DSQ_W'(new_sq[s]) - DSQ_W'(old_sq[s]);
    end
  end

  // Stage 3 to 4: squares of the axis sums, square sums times the window length
  always_comb begin
    s4_ms_d  = '0;
    sum_prod = '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      sum_prod = PR_W'($signed(axis_sum_q[i])) * PR_W'($signed(axis_sum_q[i]));
      s4_ms_d[i / AXES_PER_SENSOR] += MS_W'($unsigned(sum_prod));
    end
    for (int s = 0; s < NUM_SENSORS; s++) begin
      s4_wsq_d[s] = WSQ_W'(sqsum_q[s]) * WSQ_W'(WINDOW);
    end
  end

  // Stage 4 to 5: spread and gravity compares
  always_comb begin
    for (int s = 0; s < NUM_SENSORS; s++) begin
      spread[s] = CMP_W'(s4_wsq_q[s]) - CMP_W'(s4_ms_q[s]);
      quiet[s]  = s4_full_q && (spread[s] < CMP_W'(wlim_q[s]));
    end
    upper_ok = GCMP_W'(s4_ms_q[ACCEL]) < GCMP_W'(hi_sq_q);
    lower_ok = !lo_en_q || (GCMP_W'(s4_ms_q[ACCEL]) > GCMP_W'(lo_sq_q));
    grav_ok  = s4_full_q && upper_ok && lower_ok;
    out_d.stationary    = s4_full_q && s4_disp_ok_q && quiet[GYRO] && quiet[ACCEL] && grav_ok;
    out_d.window_full   = s4_full_q;
    out_d.gyro_quiet    = quiet[GYRO];
    out_d.accel_quiet   = quiet[ACCEL];
    out_d.gravity_match = grav_ok;
  end

  // Stage payloads: load on transfer into the stage
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_axes_q  <= in_axes;
      s1_old_v_q <= full_before;
      s1_full_q  <= full_after;
      s1_disp_q  <= in_data_i.disparity;
    end
    if (rdy2 && s1_v_q) begin
      s2_dax_q     <= s2_dax_d;
      s2_dsq_q     <= s2_dsq_d;
      s2_full_q    <= s1_full_q;
      s2_disp_ok_q <= (s1_disp_q <= max_disp_q);
    end
    if (rdy3 && s2_v_q) begin
      s3_full_q    <= s2_full_q;
      s3_disp_ok_q <= s2_disp_ok_q;
    end
    if (rdy4 && s3_v_q) begin
      s4_ms_q      <= s4_ms_d;
      s4_wsq_q     <= s4_wsq_d;
      s4_full_q    <= s3_full_q;
      s4_disp_ok_q <= s3_disp_ok_q;
    end
    if (rdy5 && s4_v_q) begin
      out_q <= out_d;
    end
  end

endmodule

// ----- rtl/core/zvd_checker.sv -----
// Port-level checker of the zero-velocity detector, bound to the top level.
// Depends on zvd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module zvd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input zvd_pkg::zvd_out_t              out_data_o
);
  import zvd_pkg::*;

  logic any_flag;

  assign any_flag = out_data_o.gyro_quiet || out_data_o.accel_quiet ||
                    out_data_o.gravity_match || out_data_o.stationary;

  // A stationary verdict needs every individual test passing
  `ZVD_ASSERT(a_stationary_needs_all, clk_i, rst_ni, out_valid_o && out_data_o.stationary |-> out_data_o.window_full && out_data_o.gyro_quiet && out_data_o.accel_quiet && out_data_o.gravity_match, "stationary without all tests passing")

  // No test may pass before the window is full
  `ZVD_ASSERT(a_flags_need_full, clk_i, rst_ni, out_valid_o && any_flag |-> out_data_o.window_full, "test flag set on a partial window")

  // Hold a result until its transfer
  `ZVD_ASSERT(a_out_held, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "result dropped while stalled")

  // No result in the cycle after reset is seen
  `ZVD_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !out_valid_o, "result valid during reset")

endmodule

bind zero_velocity_detector zvd_checker u_zvd_checker (.*);

// ----- verif/tb.sv -----
// Self-checking bench for the zero-velocity detector: predicts the five flags per sample
// and checks every output transfer. Depends on zvd_pkg and zero_velocity_detector.
`timescale 1ns / 1ps

module tb;
  import zvd_pkg::*;

  localparam int     WIN            = 32;
  localparam longint WIN_L          = WIN;
  localparam int     DIRECTED_ITEMS = 24;
  localparam int     NUM_PHASES     = 8;
  localparam int     PHASE_ITEMS    = 85;
  localparam int     HOLD_PHASE     = 6;
  localparam int     PAUSE_PHASE    = 7;
  localparam int     HOLD_CYCLES    = 300;
  localparam int     DRAIN_CYCLES   = 20;
  localparam int     WATCHDOG_LIMIT = 2000;
  localparam int     MAX_PRINTED    = 50;

  typedef enum int {
    SEG_QUIET,
    SEG_MOVING,
    SEG_NOISE,
    SEG_ZERO_ACCEL,
    SEG_CORNER
  } seg_kind_e;

  // Flag predictor: window ring, running sums and a queue of expected flags
  class flag_predictor;
    longint            ring [WIN][6];
    longint            axis_sum [6];
    longint            gyro_sq;
    longint            accel_sq;
    int                fill;
    int                wr_ptr;
    logic [DISP_W-1:0] disp_max;
    longint            gyro_lim;
    longint            accel_lim;
    longint            grav;
    longint            tol;
    zvd_out_t          expected_flags [$];
    int                errors;

    function new();
      disp_max = '1;
    endfunction

    function void set_reg(zvd_cfg_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_MAX_DISPARITY: disp_max  = val[DISP_W-1:0];
        CFG_GYRO_LIMIT:    gyro_lim  = longint'(val[LIMIT_W-1:0]);
        CFG_ACCEL_LIMIT:   accel_lim = longint'(val[LIMIT_W-1:0]);
        CFG_GRAVITY_LEVEL: grav      = longint'(val[GRAV_W-1:0]);
        CFG_GRAVITY_TOL:   tol       = longint'(val[GRAV_W-1:0]);
        default: ;
      endcase
    endfunction

    function longint sq_of_sums(int base);
      return axis_sum[base] * axis_sum[base] + axis_sum[base+1] * axis_sum[base+1] +
             axis_sum[base+2] * axis_sum[base+2];
    endfunction

    // Advance the window by one sample and queue the flags it yields
    function void note_sample(zvd_in_t s);
      longint   v [6];
      longint   old;
      longint   m2;
      longint   hi;
      longint   lo;
      logic     full;
      logic     gq;
      logic     aq;
      logic     gm;
      zvd_out_t r;
      v[0] = longint'($signed(s.gyro_x));
      v[1] = longint'($signed(s.gyro_y));
      v[2] = longint'($signed(s.gyro_z));
      v[3] = longint'($signed(s.accel_x));
      v[4] = longint'($signed(s.accel_y));
      v[5] = longint'($signed(s.accel_z));
      // drop the oldest sample once the window is full
      if (fill >= WIN) begin
        for (int i = 0; i < 6; i++) begin
          old = ring[wr_ptr][i];
          axis_sum[i] -= old;
          if (i < 3) gyro_sq -= old * old;
          else accel_sq -= old * old;
        end
      end
      for (int i = 0; i < 6; i++) begin
        ring[wr_ptr][i] = v[i];
        axis_sum[i] += v[i];
        if (i < 3) gyro_sq += v[i] * v[i];
        else accel_sq += v[i] * v[i];
      end
      wr_ptr = (wr_ptr + 1) % WIN;
      if (fill < WIN) fill++;

      full = (fill >= WIN);
      gq = full && (WIN_L * gyro_sq - sq_of_sums(0) < WIN_L * gyro_lim);
      aq = full && (WIN_L * accel_sq - sq_of_sums(3) < WIN_L * accel_lim);
      // gravity test squared; lower bound only applies when tolerance does not exceed gravity
      m2 = sq_of_sums(3);
      hi = WIN_L * (grav + tol);
      lo = WIN_L * (grav - tol);
      gm = full && (m2 < hi * hi) && ((grav < tol) || (m2 > lo * lo));
      r.stationary    = full && (s.disparity <= disp_max) && gq && aq && gm;
      r.window_full   = full;
      r.gyro_quiet    = gq;
      r.accel_quiet   = aq;
      r.gravity_match = gm;
      expected_flags.push_back(r);
    endfunction

    function int pending();
      return expected_flags.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("[%0t] flag check error: %s", $time, msg);
    endtask

    task check_flags(zvd_out_t got);
      zvd_out_t exp_flags;
      if (expected_flags.size() == 0) begin
        report("result transfer with no sample pending");
        return;
      end
      exp_flags = expected_flags.pop_front();
      if (got.stationary !== exp_flags.stationary)
        report($sformatf("stationary got %b want %b", got.stationary, exp_flags.stationary));
      if (got.window_full !== exp_flags.window_full)
        report($sformatf("window_full got %b want %b", got.window_full,
                         exp_flags.window_full));
      if (got.gyro_quiet !== exp_flags.gyro_quiet)
        report($sformatf("gyro_quiet got %b want %b", got.gyro_quiet, exp_flags.gyro_quiet));
      if (got.accel_quiet !== exp_flags.accel_quiet)
        report($sformatf("accel_quiet got %b want %b", got.accel_quiet,
                         exp_flags.accel_quiet));
      if (got.gravity_match !== exp_flags.gravity_match)
        report($sformatf("gravity_match got %b want %b", got.gravity_match,
                         exp_flags.gravity_match));
    endtask
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  zvd_in_t               in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  zvd_out_t              out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  flag_predictor board = new();

  int send_idle_pct  = 18;
  int recv_idle_pct  = 77;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;

  // Stimulus shaping for the current segment and phase
  longint            gyro_bias [3];
  longint            accel_base [3];
  int                noise_amp;
  longint            grav_cur;
  longint            tol_cur;
  logic [DISP_W-1:0] disp_cur = '1;

  zero_velocity_detector #(.WINDOW(WIN)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor: check results first, then record accepted samples
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) board.check_flags(out_data_o);
    if (in_valid_i && !in_stall_o) board.note_sample(in_data_i);
  end

  // Watchdog: end the run when nothing transfers for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAILURE");
    $finish;
  end

  function automatic logic [15:0] sat16(longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic longint jitter(int amp);
    return longint'($urandom_range(2 * amp)) - amp;
  endfunction

  function automatic logic [15:0] corner_value(int sel);
    case (sel)
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      4:       return 16'h0001;
      5:       return 16'h5555;
      default: return 16'hAAAA;
    endcase
  endfunction

  function automatic zvd_in_t pack_sample(input logic [15:0] ax [6], input logic [15:0] disp);
    zvd_in_t s;
    s.gyro_x    = ax[0];
    s.gyro_y    = ax[1];
    s.gyro_z    = ax[2];
    s.accel_x   = ax[3];
    s.accel_y   = ax[4];
    s.accel_z   = ax[5];
    s.disparity = disp;
    return s;
  endfunction

  // Build one sample of the given segment kind around the current bias and gravity vector
  function automatic zvd_in_t make_sample(seg_kind_e kind);
    logic [15:0] ax [6];
    logic [15:0] disp;
    int          amp;
    amp = (kind == SEG_MOVING) ? noise_amp * 8 + 64 : noise_amp;
    for (int i = 0; i < 3; i++) begin
      ax[i]   = sat16(gyro_bias[i] + jitter(amp));
      ax[i+3] = (kind == SEG_ZERO_ACCEL) ? 16'h0000 : sat16(accel_base[i] + jitter(amp));
    end
    disp = $urandom_range(1) ? 16'($urandom_range(disp_cur)) : 16'($urandom_range(16'hFFFF));
    if (kind == SEG_NOISE) begin
      for (int i = 0; i < 6; i++) ax[i] = 16'($urandom);
      disp = 16'($urandom);
    end else if (kind == SEG_CORNER) begin
      for (int i = 0; i < 6; i++) ax[i] = corner_value($urandom_range(6));
      disp = corner_value($urandom_range(6));
    end
    return pack_sample(ax, disp);
  endfunction

  // Offer one sample, idling first at random, and hold it until transferred
  task automatic send_sample(input zvd_in_t item);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Stop offering and wait for every pending result
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
  endtask

  task automatic write_reg(input zvd_cfg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.set_reg(idx, val);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [15:0]         ax [6];
    logic [DISP_W-1:0]   p_disp;
    logic [LIMIT_W-1:0]  p_glim;
    logic [LIMIT_W-1:0]  p_alim;
    logic [GRAV_W-1:0]   p_grav;
    logic [GRAV_W-1:0]   p_tol;
    seg_kind_e           kind;
    int                  pick;
    int                  seg_len;
    int                  count;
    longint              nominal;
    longint              tmp;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners on the reset configuration, window not yet full
    for (int i = 0; i < DIRECTED_ITEMS; i++) begin
      for (int f = 0; f < 6; f++) ax[f] = corner_value(i < 7 ? i : (i + f * 3) % 7);
      send_sample(pack_sample(ax, corner_value((i * 3) % 7)));
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      // idle pattern: sender light / receiver heavy, then swapped, then none
      if (p < 3) begin
        send_idle_pct <= 18;
        recv_idle_pct <= 77;
      end else if (p < 6) begin
        send_idle_pct <= 77;
        recv_idle_pct <= 18;
      end else begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end

      noise_amp = (p % 4 == 0) ? 2 : (p % 4 == 1) ? 8 : (p % 4 == 2) ? 30 : 120;
      nominal   = longint'(WIN) * noise_amp * noise_amp;
      p_disp = DISP_W'($urandom_range(16'hFFFF));
      p_glim = LIMIT_W'(nominal * $urandom_range(250, 40) / 100);
      p_alim = LIMIT_W'(nominal * $urandom_range(250, 40) / 100);
      p_grav = GRAV_W'($urandom_range(32767, 1000));
      p_tol  = GRAV_W'($urandom_range(p_grav / 8));
      case (p)
        0: begin
          p_grav = GRAV_W'(16384);
          p_tol  = GRAV_W'($urandom_range(2000, 100));
        end
        1: begin
          p_disp = '0;
          p_glim = '0;
          p_alim = '0;
          p_grav = '0;
          p_tol  = '0;
        end
        2: begin
          // tolerance equal to gravity, limits wide open
          p_disp = '1;
          p_glim = '1;
          p_alim = '1;
          p_grav = GRAV_W'($urandom_range(3000, 100));
          p_tol  = p_grav;
        end
        3: begin
          p_grav = '1;
          p_tol  = '1;
        end
        4: begin
          // tolerance at or above gravity
          p_grav = GRAV_W'($urandom_range(20000, 1000));
          p_tol  = GRAV_W'($urandom_range(32767, p_grav));
        end
        default: ;
      endcase
      write_reg(CFG_MAX_DISPARITY, CFG_DATA_W'(p_disp));
      write_reg(CFG_GYRO_LIMIT, CFG_DATA_W'(p_glim));
      write_reg(CFG_ACCEL_LIMIT, CFG_DATA_W'(p_alim));
      write_reg(CFG_GRAVITY_LEVEL, CFG_DATA_W'(p_grav));
      write_reg(CFG_GRAVITY_TOL, CFG_DATA_W'(p_tol));
      disp_cur = p_disp;
      grav_cur = longint'(p_grav);
      tol_cur  = longint'(p_tol);

      count = 0;
      while (count < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 55) kind = SEG_QUIET;
        else if (pick < 75) kind = SEG_MOVING;
        else if (pick < 85) kind = SEG_NOISE;
        else if (pick < 95) kind = SEG_ZERO_ACCEL;
        else kind = SEG_CORNER;
        if (p == 2 && count == 0) kind = SEG_ZERO_ACCEL;
        seg_len = (kind == SEG_ZERO_ACCEL) ? WIN + 8 : $urandom_range(48, 8);

        // segment bias and gravity vector near the configured magnitude
        for (int i = 0; i < 3; i++) gyro_bias[i] = jitter(40);
        accel_base[0] = jitter(int'(tol_cur * 2 + 8));
        accel_base[1] = jitter(int'(tol_cur * 2 + 8));
        accel_base[2] = grav_cur + jitter(int'(tol_cur * 2 + 8));
        if ($urandom_range(1)) begin
          tmp           = accel_base[0];
          accel_base[0] = -accel_base[2];
          accel_base[2] = tmp;
        end

        for (int k = 0; k < seg_len && count < PHASE_ITEMS; k++) begin
          if (p == HOLD_PHASE && count == 30) hold_requests <= hold_requests + 1;
          if (p == PAUSE_PHASE && count == 40) wait_drained();
          send_sample(make_sample(kind));
          count++;
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.pending() != 0)
      board.report($sformatf("%0d results never arrived", board.pending()));
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/zvd_pkg.sv
rtl/core/zvd_ram.sv
rtl/core/zero_velocity_detector.sv
rtl/core/zvd_checker.sv
verif/tb.sv
